@@ rtl/acrm_pkg.sv @@
// Shared types, constants and register codes for the audio channel remap mixer.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package acrm_pkg;

	localparam int CHANNELS         = 9;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int SLOT_W           = 4;
	localparam int MAP_W            = CHANNELS * SLOT_W;
	localparam int CH_CNT_W         = 4;
	localparam int CNT_W            = $clog2(CHANNELS + 1);
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = MAP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_MAP = 2'd0,
		REG_NORMALIZE   = 2'd1,
		REG_IN_COUNT    = 2'd2,
		REG_OUT_COUNT   = 2'd3
	} reg_idx_t;

	// Per-lane routing control: keep the sample, its output slot, its divisor.
	typedef struct packed {
		logic              keep;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  div;
	} lane_ctl_t;

	// Identity routing: input i goes to slot i.
	function automatic logic [MAP_W-1:0] map_reset();
		logic [MAP_W-1:0] m;
		m = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			m[i*SLOT_W +: SLOT_W] = SLOT_W'(i);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

@@ rtl/acrm_lane.sv @@
// One processing lane: magnitude, divide by the slot count through a reciprocal
// multiply, restore the sign. Depends on acrm_pkg.
`default_nettype none
module acrm_lane
	import acrm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          adv1,
	input  wire logic                          adv2,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire lane_ctl_t                     ctl,
	output lane_ctl_t                          ctl_out,
	output logic signed [SAMPLE_BITS-1:0]      val
);

	// Exact for every magnitude up to 2^(SAMPLE_BITS-1) and divisors up to 9.
	localparam int K = SAMPLE_BITS + 3;

	logic [K:0]             recip_tab [CHANNELS+1];
	logic [SAMPLE_BITS-1:0] abs_s1;
	logic                   neg_s1;
	lane_ctl_t              ctl_s1;
	logic [SAMPLE_BITS+K:0] prod_s2;
	logic                   neg_s2;
	lane_ctl_t              ctl_s2;
	logic [SAMPLE_BITS-1:0] quo;

	for (genvar g = 0; g <= CHANNELS; g++) begin : g_recip
		localparam longint unsigned RECIP =
			((64'd1 << K) + 64'(g) - 64'd1) / (64'(g) + ((g == 0) ? 64'd1 : 64'd0));
		assign recip_tab[g] = RECIP[K:0];
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			neg_s1 <= sample[SAMPLE_BITS-1];
			abs_s1 <= sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			prod_s2 <= abs_s1 * recip_tab[ctl_s1.div];
			neg_s2  <= neg_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	assign quo     = prod_s2[K +: SAMPLE_BITS];
	assign val     = neg_s2 ? $signed(SAMPLE_BITS'(-quo)) : $signed(quo);
	assign ctl_out = ctl_s2;

endmodule
`default_nettype wire

@@ rtl/acrm_merge.sv @@
// Merging stage: adds every kept lane into its output slot and registers the mix.
// Depends on acrm_pkg.
`default_nettype none
module acrm_merge
	import acrm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          adv,
	input  wire logic signed [SAMPLE_BITS-1:0] lane_val [CHANNELS],
	input  wire lane_ctl_t                     lane_ctl [CHANNELS],
	output logic signed [SAMPLE_BITS-1:0]      mix_q [CHANNELS]
);

	logic signed [SAMPLE_BITS-1:0] sum [CHANNELS];

	// Sums wrap at the sample width.
	always_comb begin
		for (int j = 0; j < CHANNELS; j++) begin
			sum[j] = '0;
			for (int i = 0; i < CHANNELS; i++) begin
				if (lane_ctl[i].keep && (lane_ctl[i].slot == SLOT_W'(j))) begin
					sum[j] = sum[j] + lane_val[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mix_q <= sum;
		end
	end

endmodule
`default_nettype wire

@@ rtl/audio_channel_remap_mixer.sv @@
// Audio channel remap and downmix, top level: configuration registers, routing
// counts, stage control. Depends on acrm_pkg, acrm_lane and acrm_merge.
//
// Usage:
//   Input channel: in_valid/in_ready move one frame request of nine samples
//   plus end_of_block. Output channel: out_valid/out_ready move one mixed
//   frame plus last_frame. Configuration: cfg_valid/cfg_ready with cfg_index
//   (0 map, 1 normalise flag, 2 input count, 3 output count) and cfg_data;
//   cfg_ready is always high. Write configuration only while no frame is in flight.
// Pipeline: three register stages (capture, multiply, mix); out_valid rises
//   once the frame reaches the mix register.
// Throughput: one frame per cycle while out_ready is high; each of the nine lanes
//   holds one reciprocal multiplier and the merging stage one adder tree per slot.
// Reset: arst_n clears all stage valids and loads the identity map,
//   normalize on and nine channels in and out.
// Stall: when out_ready is low the mixed frame is held; each stage advances
//   while the one after it is empty or moving, so the pipeline fills up
//   before in_ready drops; once all three stages are full in_ready follows
//   out_ready within the same cycle.
`default_nettype none
module audio_channel_remap_mixer
	import acrm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_0,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_1,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_2,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_3,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_4,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_5,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_6,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_7,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample_8,
	input  wire logic                          end_of_block,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_0,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_1,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_2,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_3,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_4,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_5,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_6,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_7,
	output logic signed [SAMPLE_BITS-1:0]      out_sample_8,
	output logic                               last_frame
);

	// Configuration registers
	logic [MAP_W-1:0]    channel_map_q;
	logic                normalize_q;
	logic [CH_CNT_W-1:0] in_count_q;
	logic [CH_CNT_W-1:0] out_count_q;

	// Stage control
	logic adv1, adv2, adv3;
	logic vld_s1, vld_s2, out_valid_q;
	logic eob_s1, eob_s2, last_q;

	// Routing
	logic [CH_CNT_W-1:0]           nin_eff, nout_eff;
	lane_ctl_t                     ctl_in   [CHANNELS];
	lane_ctl_t                     ctl_lane [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] sample_in [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] lane_val  [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] mix_q     [CHANNELS];
	logic [CHANNELS-1:0]           keep_vec, div_nz_vec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_map_q <= map_reset();
			normalize_q   <= 1'b1;
			in_count_q    <= CH_CNT_W'(CHANNELS);
			out_count_q   <= CH_CNT_W'(CHANNELS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNEL_MAP: channel_map_q <= cfg_data[MAP_W-1:0];
				REG_NORMALIZE:   normalize_q   <= cfg_data[0];
				REG_IN_COUNT:    in_count_q    <= cfg_data[CH_CNT_W-1:0];
				REG_OUT_COUNT:   out_count_q   <= cfg_data[CH_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign sample_in[0] = in_sample_0;
	assign sample_in[1] = in_sample_1;
	assign sample_in[2] = in_sample_2;
	assign sample_in[3] = in_sample_3;
	assign sample_in[4] = in_sample_4;
	assign sample_in[5] = in_sample_5;
	assign sample_in[6] = in_sample_6;
	assign sample_in[7] = in_sample_7;
	assign sample_in[8] = in_sample_8;

	// Clamp the channel counts to the lane count.
	assign nin_eff  = (in_count_q > CH_CNT_W'(CHANNELS)) ?
		CH_CNT_W'(CHANNELS) : in_count_q;
	assign nout_eff = (out_count_q > CH_CNT_W'(CHANNELS)) ?
		CH_CNT_W'(CHANNELS) : out_count_q;

	// Derive per-lane routing from the configuration alone: drop inactive inputs
	// and out-of-range slots, then count how many kept inputs share each slot.
	always_comb begin
		logic [SLOT_W-1:0] slot [CHANNELS];
		logic              keep [CHANNELS];
		logic [CNT_W-1:0]  cnt;
		for (int i = 0; i < CHANNELS; i++) begin
			slot[i] = channel_map_q[i*SLOT_W +: SLOT_W];
			keep[i] = (CH_CNT_W'(i) < nin_eff) && (CH_CNT_W'(slot[i]) < nout_eff);
		end
		for (int i = 0; i < CHANNELS; i++) begin
			cnt = '0;
			for (int j = 0; j < CHANNELS; j++) begin
				if (keep[j] && (slot[j] == slot[i])) begin
					cnt = cnt + 1'b1;
				end
			end
			ctl_in[i].keep = keep[i];
			ctl_in[i].slot = slot[i];
			ctl_in[i].div  = (normalize_q && keep[i]) ? cnt : CNT_W'(1);
			keep_vec[i]    = keep[i];
			div_nz_vec[i]  = (ctl_in[i].div != '0);
		end
	end

	// Each stage advances when the next one is empty or advancing itself.
	assign adv3     = !out_valid_q || out_ready;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) eob_s1 <= end_of_block;
		if (adv2) eob_s2 <= eob_s1;
		if (adv3) last_q <= eob_s2;
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		acrm_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk     (clk),
			.adv1    (adv1),
			.adv2    (adv2),
			.sample  (sample_in[i]),
			.ctl     (ctl_in[i]),
			.ctl_out (ctl_lane[i]),
			.val     (lane_val[i])
		);
	end

	acrm_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk      (clk),
		.adv      (adv3),
		.lane_val (lane_val),
		.lane_ctl (ctl_lane),
		.mix_q    (mix_q)
	);

	assign out_valid    = out_valid_q;
	assign last_frame   = last_q;
	assign out_sample_0 = mix_q[0];
	assign out_sample_1 = mix_q[1];
	assign out_sample_2 = mix_q[2];
	assign out_sample_3 = mix_q[3];
	assign out_sample_4 = mix_q[4];
	assign out_sample_5 = mix_q[5];
	assign out_sample_6 = mix_q[6];
	assign out_sample_7 = mix_q[7];
	assign out_sample_8 = mix_q[8];

`ifndef SYNTHESIS
	// An empty output register must never hold back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("in_ready low with an empty output stage");

	// An accepted request always lands in the capture stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("accepted request lost at capture");

	// A delivered frame with nothing behind it leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld_s2) |=> !out_valid)
		else $error("output valid without a frame behind it");

	// Every kept input has a non-zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(keep_vec & ~div_nz_vec) == '0)
		else $error("kept lane with zero divisor");
`endif

endmodule
`default_nettype wire
